// File: rtl/core/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Types and fixed constants shared by the Hilbert envelope detector modules.
// ----------------------------------------------------------------------------
package hed_pkg;

    // Sample window and Hilbert FIR
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_LEN     = 9;
    localparam int FILL_BITS   = 4;
    localparam int HIL_FRAC    = 14;
    localparam int TAP_BITS    = 16;
    localparam logic signed [TAP_BITS-1:0] TAP_OUTER = 16'sd6072;
    localparam logic signed [TAP_BITS-1:0] TAP_INNER = 16'sd10463;
    localparam int HSUM_BITS   = SAMPLE_BITS + 16;
    localparam int Q_BITS      = SAMPLE_BITS + 2;

    // Magnitude: sum of squares and its integer root
    localparam int SUMSQ_BITS  = 2 * Q_BITS;
    localparam int MAG_BITS    = Q_BITS;
    localparam int ROOT_STEPS  = SUMSQ_BITS / 2;

    // Biquad arithmetic
    localparam int STATE_BITS  = 40;
    localparam int SUM_BITS    = STATE_BITS + 2;
    localparam int CHUNK_BITS  = 21;
    localparam int OPND_BITS   = CHUNK_BITS + 1;
    localparam int COEF_BITS   = 22;
    localparam int PROD_BITS   = COEF_BITS + OPND_BITS;
    localparam int ACC_BITS    = 64;
    localparam int COEF_FRAC   = 20;
    localparam logic signed [COEF_BITS-1:0] COEF_A1 = -22'sd1911234;
    localparam logic signed [COEF_BITS-1:0] COEF_A2 = 22'sd877849;
    localparam logic signed [COEF_BITS-1:0] COEF_G  = 22'sd3798;

    // Output
    localparam int ENV_BITS    = 17;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] rf_sample;
        logic                          line_start;
    } rf_beat_t;

    typedef struct packed {
        logic [ENV_BITS-1:0] envelope;
        logic                first_of_line;
    } env_beat_t;

    typedef struct packed {
        logic [SUMSQ_BITS-1:0] sumsq;
        logic                  first;
    } sq_item_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] level;
        logic                 empty;
        logic                 full;
    } queue_stat_t;

endpackage

// File: rtl/core/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Accepts RF beats, keeps the 9-sample window, computes the Hilbert
// quadrature term and the sum of squares in a 3-stage pipeline and pushes
// one item per full window into the queue.
// ----------------------------------------------------------------------------
module hed_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rf_valid,
    output logic                 rf_ready,
    input  hed_pkg::rf_beat_t    rf_beat,
    input  hed_pkg::queue_stat_t q_stat,
    output logic                 push,
    output hed_pkg::sq_item_t    push_item
);

    localparam int S  = hed_pkg::SAMPLE_BITS;
    localparam int HW = hed_pkg::HSUM_BITS;
    localparam int QW = hed_pkg::Q_BITS;
    localparam int SW = hed_pkg::SUMSQ_BITS;

    logic signed [S-1:0]  win_reg [hed_pkg::WIN_LEN];
    logic                 mark_reg [hed_pkg::WIN_LEN];
    logic [hed_pkg::FILL_BITS-1:0] fill_reg;

    logic accept;
    logic full_after;
    logic [hed_pkg::QCNT_BITS-1:0] credit_sum;

    // pipeline registers
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [HW-1:0] p_outer_reg, p_inner_reg;
    logic signed [S-1:0]  s1_i_reg, s2_i_reg;
    logic                 s1_first_reg, s2_first_reg, s3_first_reg;
    logic signed [QW-1:0] q_reg;
    logic [SW-1:0]        q2_reg, i2_reg;

    logic signed [HW-1:0] d_outer, d_inner, p_outer_next, p_inner_next;
    logic signed [HW-1:0] hsum, hround;
    logic signed [2*QW-1:0] q_sq;
    logic signed [2*S-1:0]  i_sq;

    // credit check: items in flight plus queued never exceed the queue depth
    assign credit_sum = q_stat.level + hed_pkg::QCNT_BITS'(s1_valid_reg)
                      + hed_pkg::QCNT_BITS'(s2_valid_reg)
                      + hed_pkg::QCNT_BITS'(s3_valid_reg);
    assign rf_ready   = credit_sum < hed_pkg::QCNT_BITS'(hed_pkg::QUEUE_DEPTH);
    assign accept     = rf_valid && rf_ready;
    assign full_after = fill_reg >= hed_pkg::FILL_BITS'(hed_pkg::WIN_LEN - 1);

    // window shift line
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < hed_pkg::WIN_LEN - 1; k++)
            begin
                win_reg[k]  <= win_reg[k+1];
                mark_reg[k] <= mark_reg[k+1];
            end
            win_reg[hed_pkg::WIN_LEN-1]  <= rf_beat.rf_sample;
            mark_reg[hed_pkg::WIN_LEN-1] <= rf_beat.line_start;
        end
    end

    // fill count, saturates at one less than the window length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept && !full_after)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    // stage 1 taps, read from the window as it stands before this shift
    assign d_outer      = HW'(win_reg[2]) - HW'(win_reg[8]);
    assign d_inner      = HW'(win_reg[4]) - HW'(win_reg[6]);
    assign p_outer_next = HW'(hed_pkg::TAP_OUTER) * d_outer;
    assign p_inner_next = HW'(hed_pkg::TAP_INNER) * d_inner;

    // stage 2: tap sum, round half up
    assign hsum   = p_outer_reg + p_inner_reg;
    assign hround = (hsum + (HW'(1) <<< (hed_pkg::HIL_FRAC - 1))) >>> hed_pkg::HIL_FRAC;

    // stage 3: squares
    assign q_sq = q_reg * q_reg;
    assign i_sq = s2_i_reg * s2_i_reg;

    always_ff @(posedge clk)
    begin
        p_outer_reg  <= p_outer_next;
        p_inner_reg  <= p_inner_next;
        s1_i_reg     <= win_reg[5];
        s1_first_reg <= mark_reg[1];
        q_reg        <= QW'(hround);
        s2_i_reg     <= s1_i_reg;
        s2_first_reg <= s1_first_reg;
        q2_reg       <= SW'($unsigned(q_sq));
        i2_reg       <= SW'($unsigned(i_sq));
        s3_first_reg <= s2_first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && full_after;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // final add feeds the queue directly
    assign push            = s3_valid_reg;
    assign push_item.sumsq = q2_reg + i2_reg;
    assign push_item.first = s3_first_reg;

endmodule

// File: rtl/core/hed_queue.sv
// ----------------------------------------------------------------------------
// hed_queue
// Short FIFO of sum-of-squares items between the front and the back.
// ----------------------------------------------------------------------------
module hed_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hed_pkg::sq_item_t    push_item,
    input  logic                 pop,
    output hed_pkg::sq_item_t    head_item,
    output hed_pkg::queue_stat_t q_stat
);

    hed_pkg::sq_item_t mem [hed_pkg::QUEUE_DEPTH];

    logic [hed_pkg::QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [hed_pkg::QCNT_BITS-1:0] level_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    assign head_item    = mem[rd_ptr_reg];
    assign q_stat.level = level_reg;
    assign q_stat.empty = level_reg == '0;
    assign q_stat.full  = level_reg == hed_pkg::QCNT_BITS'(hed_pkg::QUEUE_DEPTH);

endmodule

// File: rtl/core/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Pops queued items, takes the integer square root one result bit per
// cycle, runs the line-cleared biquad on a shared 22x22 multiplier over
// chunked operands and holds the result in the output register.
// ----------------------------------------------------------------------------
module hed_back #(
    parameter int STATE_FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hed_pkg::sq_item_t    head_item,
    input  hed_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 env_valid,
    input  logic                 env_ready,
    output hed_pkg::env_beat_t   env_beat
);

    localparam int MW    = hed_pkg::MAG_BITS;
    localparam int SQW   = hed_pkg::SUMSQ_BITS;
    localparam int REM_W = MW + 3;
    localparam int CNT_W = $clog2(hed_pkg::ROOT_STEPS);
    localparam int AW    = hed_pkg::ACC_BITS;
    localparam int STW   = hed_pkg::STATE_BITS;
    localparam int SUMW  = hed_pkg::SUM_BITS;
    localparam int CK    = hed_pkg::CHUNK_BITS;
    localparam int X_W   = MW + STATE_FRAC_BITS;
    localparam int FB_W  = AW - hed_pkg::COEF_FRAC + 2;
    localparam int DIFF_W = (X_W + 2 > FB_W) ? X_W + 2 : FB_W;
    localparam int Y_SH  = hed_pkg::COEF_FRAC + STATE_FRAC_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROOT   = 3'd1;
    localparam logic [2:0] ST_FB     = 3'd2;
    localparam logic [2:0] ST_FB_ADD = 3'd3;
    localparam logic [2:0] ST_W0     = 3'd4;
    localparam logic [2:0] ST_GS     = 3'd5;
    localparam logic [2:0] ST_GS_ADD = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       step_reg;
    logic             first_reg;

    logic [SQW-1:0]   rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [MW-1:0]    root_reg;

    logic signed [STW-1:0]  d1_reg, d2_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [hed_pkg::PROD_BITS-1:0] prod_reg;
    logic             sh_reg;
    logic signed [AW-1:0] acc_reg;

    logic               env_valid_reg;
    hed_pkg::env_beat_t env_beat_reg;

    // root step
    logic [REM_W-1:0] rem_shift, trial, rem_next;
    logic [MW-1:0]    root_next;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[SQW-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});

    always_comb
    begin
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[MW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[MW-2:0], 1'b0};
        end
    end

    // multiplier operand select
    logic signed [SUMW-1:0] opnd_src;
    logic signed [hed_pkg::OPND_BITS-1:0] opnd_sel;
    logic signed [hed_pkg::COEF_BITS-1:0] coef_sel;
    logic signed [hed_pkg::PROD_BITS-1:0] prod_mul;
    logic signed [AW-1:0] prod_ext, acc_add;

    always_comb
    begin
        if (state_reg == ST_GS)
        begin
            opnd_src = sum_reg;
            coef_sel = hed_pkg::COEF_G;
        end
        else if (step_reg[1])
        begin
            opnd_src = SUMW'(d2_reg);
            coef_sel = hed_pkg::COEF_A2;
        end
        else
        begin
            opnd_src = SUMW'(d1_reg);
            coef_sel = hed_pkg::COEF_A1;
        end
        if (step_reg[0])
        begin
            opnd_sel = {opnd_src[SUMW-1], opnd_src[SUMW-1:CK]};
        end
        else
        begin
            opnd_sel = {1'b0, opnd_src[CK-1:0]};
        end
    end

    assign prod_mul = coef_sel * opnd_sel;
    assign prod_ext = AW'(prod_reg);
    assign acc_add  = acc_reg + (sh_reg ? (prod_ext <<< CK) : prod_ext);

    // new biquad state w0 = sat40(x - round(fb))
    logic signed [AW-1:0]     fb_round;
    logic signed [DIFF_W-1:0] x_ext, diff;
    logic signed [STW-1:0]    w0;
    logic [DIFF_W-STW:0]      diff_top;

    assign fb_round = (acc_reg + (AW'(1) <<< (hed_pkg::COEF_FRAC - 1))) >>> hed_pkg::COEF_FRAC;
    assign x_ext    = $signed(DIFF_W'(root_reg) << STATE_FRAC_BITS);
    assign diff     = x_ext - DIFF_W'(fb_round);
    assign diff_top = diff[DIFF_W-1:STW-1];

    always_comb
    begin
        if ((&diff_top) || !(|diff_top))
        begin
            w0 = STW'(diff);
        end
        else if (diff[DIFF_W-1])
        begin
            w0 = {1'b1, {(STW-1){1'b0}}};
        end
        else
        begin
            w0 = {1'b0, {(STW-1){1'b1}}};
        end
    end

    // output: round, clamp at zero, saturate
    logic signed [AW-1:0]         y_round;
    logic [hed_pkg::ENV_BITS-1:0] y_env;

    assign y_round = (acc_reg + (AW'(1) <<< (Y_SH - 1))) >>> Y_SH;

    always_comb
    begin
        if (y_round[AW-1])
        begin
            y_env = '0;
        end
        else if (|y_round[AW-1:hed_pkg::ENV_BITS])
        begin
            y_env = '1;
        end
        else
        begin
            y_env = y_round[hed_pkg::ENV_BITS-1:0];
        end
    end

    logic slot_free;
    assign slot_free = !env_valid_reg || env_ready;
    assign pop       = (state_reg == ST_IDLE) && !q_stat.empty;

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rad_reg   <= head_item.sumsq;
                first_reg <= head_item.first;
                rem_reg   <= '0;
                root_reg  <= '0;
            end
            ST_ROOT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                acc_reg  <= '0;
                prod_reg <= '0;
            end
            ST_FB, ST_GS:
            begin
                acc_reg  <= acc_add;
                prod_reg <= prod_mul;
                sh_reg   <= step_reg[0];
            end
            ST_FB_ADD, ST_GS_ADD:
            begin
                acc_reg <= acc_add;
            end
            ST_W0:
            begin
                sum_reg  <= SUMW'(w0) + (SUMW'(d1_reg) <<< 1) + SUMW'(d2_reg);
                acc_reg  <= '0;
                prod_reg <= '0;
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    env_beat_reg.envelope      <= y_env;
                    env_beat_reg.first_of_line <= first_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer and biquad state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            env_valid_reg <= 1'b0;
        end
        else
        begin
            // output valid: set on a new result, cleared once the beat is taken
            if ((state_reg == ST_OUT) && slot_free)
            begin
                env_valid_reg <= 1'b1;
            end
            else if (env_valid_reg && env_ready)
            begin
                env_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (pop)
                    begin
                        // line start clears the filter before this sample
                        if (head_item.first)
                        begin
                            d1_reg <= '0;
                            d2_reg <= '0;
                        end
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(hed_pkg::ROOT_STEPS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_FB;
                    end
                end
                ST_FB:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= ST_FB_ADD;
                    end
                end
                ST_FB_ADD:
                begin
                    state_reg <= ST_W0;
                end
                ST_W0:
                begin
                    d2_reg    <= d1_reg;
                    d1_reg    <= w0;
                    step_reg  <= '0;
                    state_reg <= ST_GS;
                end
                ST_GS:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg[0])
                    begin
                        state_reg <= ST_GS_ADD;
                    end
                end
                ST_GS_ADD:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign env_valid = env_valid_reg;
    assign env_beat  = env_beat_reg;

endmodule

// File: rtl/core/hilbert_envelope_detector.sv
// Path: 3 front stages into the queue, then the back-end sequencer runs from pop
// through root, feedback, new state and gain steps to the output register.
// Throughput: the back end pops only when idle; its 18-step square root (one result bit
// per cycle) and the six chunked biquad multiplies on its shared multiplier limit it;
// the front accepts beats every cycle until the 4-entry queue is committed.
// The first 8 beats after reset only fill the window and give no result.
// Reset: rst_n asynchronous, active low; clears fill count, queue, sequencer, filter.
// ----------------------------------------------------------------------------
// hilbert_envelope_detector
// Envelope detector: 9-tap Hilbert quadrature, magnitude by integer square
// root, low-pass biquad cleared at each line start, clamped 17-bit output.
// ----------------------------------------------------------------------------
module hilbert_envelope_detector #(
    parameter int STATE_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rf_valid,
    output logic               rf_ready,
    input  hed_pkg::rf_beat_t  rf_beat,
    output logic               env_valid,
    input  logic               env_ready,
    output hed_pkg::env_beat_t env_beat
);

    hed_pkg::queue_stat_t q_stat;
    hed_pkg::sq_item_t    push_item, head_item;
    logic                 push, pop;

    hed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rf_valid  (rf_valid),
        .rf_ready  (rf_ready),
        .rf_beat   (rf_beat),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    hed_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    hed_back #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_stat    (q_stat),
        .pop       (pop),
        .env_valid (env_valid),
        .env_ready (env_ready),
        .env_beat  (env_beat)
    );

    // front credit accounting must never overrun the queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    // back end pops only queued items
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // a pop without a push lowers the level by exactly one
    a_level_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (q_stat.level == $past(q_stat.level) - 1'b1))
        else $error("queue level mismatch after pop");

endmodule

// File: dv/hilbert_envelope_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hilbert_envelope_checker
// Watches both channels of the envelope detector. Each accepted RF beat runs
// through a cycle-free model of the window, Hilbert sum, root and biquad, and
// each accepted envelope beat is compared field by field with the oldest
// prediction. Mismatch, pending and checked counts go to the testbench top.
// ----------------------------------------------------------------------------
module hilbert_envelope_checker #(
    parameter int STATE_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rf_valid,
    input  logic               rf_ready,
    input  hed_pkg::rf_beat_t  rf_beat,
    input  logic               env_valid,
    input  logic               env_ready,
    input  hed_pkg::env_beat_t env_beat,
    output int                 error_count,
    output int                 pending_count,
    output int                 checked_count
);

    // Filter constants: Hilbert taps in Q1.14, biquad coefficients in Q.20
    localparam int     TAPS          = 9;
    localparam longint OUTER_TAP     = 6072;
    localparam longint INNER_TAP     = 10463;
    localparam int     HILBERT_SHIFT = 14;
    localparam longint FB_A1         = -1911234;
    localparam longint FB_A2         = 877849;
    localparam longint FF_GAIN       = 3798;
    localparam int     COEF_SHIFT    = 20;
    localparam longint STATE_MAX     = (longint'(1) <<< 39) - 1;
    localparam longint STATE_MIN     = -(longint'(1) <<< 39);
    localparam longint ENV_CEIL      = (longint'(1) <<< hed_pkg::ENV_BITS) - 1;

    logic signed [hed_pkg::SAMPLE_BITS-1:0] rf_window [TAPS];
    logic                                   start_window [TAPS];
    int                                     window_fill;
    longint                                 delay_one;
    longint                                 delay_two;
    hed_pkg::env_beat_t                     envelope_queue [$];
    hed_pkg::env_beat_t                     oldest;
    int                                     mismatches;
    int                                     checks;

    // floor(v / 2^s + 1/2)
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // floor(sqrt(v)), one result bit per step from the top
    function automatic longint int_root(input longint v);
        longint root;
        longint trial;
        int     b;
        root = 0;
        for (b = 19; b >= 0; b--)
        begin
            trial = root | (longint'(1) <<< b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d (envelope beat %0d)",
                 $time, what, got, want, checks);
        mismatches++;
    endtask

    // Shift one RF beat in; once the window is full, queue the middle sample's envelope
    task automatic predict_envelope(input hed_pkg::rf_beat_t beat);
        longint             hsum;
        longint             quad;
        longint             inph;
        longint             mag;
        longint             feedback;
        longint             w0;
        longint             y;
        hed_pkg::env_beat_t want;
        int                 k;
        for (k = 0; k < TAPS - 1; k++)
        begin
            rf_window[k]    = rf_window[k + 1];
            start_window[k] = start_window[k + 1];
        end
        rf_window[TAPS - 1]    = beat.rf_sample;
        start_window[TAPS - 1] = beat.line_start;
        if (window_fill < TAPS)
            window_fill = window_fill + 1;
        if (window_fill == TAPS)
        begin
            hsum = OUTER_TAP * (longint'(rf_window[1]) - longint'(rf_window[7]))
                 + INNER_TAP * (longint'(rf_window[3]) - longint'(rf_window[5]));
            quad = round_half_up(hsum, HILBERT_SHIFT);
            inph = longint'(rf_window[4]);
            mag  = int_root(inph * inph + quad * quad);
            // line start on the oldest sample clears the biquad first
            if (start_window[0])
            begin
                delay_one = 0;
                delay_two = 0;
            end
            feedback = FB_A1 * delay_one + FB_A2 * delay_two;
            w0 = clip((mag <<< STATE_FRAC_BITS) - round_half_up(feedback, COEF_SHIFT),
                      STATE_MIN, STATE_MAX);
            y = round_half_up(FF_GAIN * (w0 + 2 * delay_one + delay_two),
                              COEF_SHIFT + STATE_FRAC_BITS);
            delay_two = delay_one;
            delay_one = w0;
            y = clip(y, 0, ENV_CEIL);
            want.envelope      = y[hed_pkg::ENV_BITS-1:0];
            want.first_of_line = start_window[0];
            envelope_queue.push_back(want);
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                rf_window[k]    = '0;
                start_window[k] = 1'b0;
            end
            window_fill = 0;
            delay_one   = 0;
            delay_two   = 0;
            envelope_queue.delete();
            mismatches  = 0;
            checks      = 0;
        end
        else
        begin
            if (rf_valid && rf_ready)
                predict_envelope(rf_beat);
            if (env_valid && env_ready)
            begin
                if (envelope_queue.size() == 0)
                    report_mismatch("unexpected envelope beat",
                                    longint'(env_beat.envelope), -1);
                else
                begin
                    oldest = envelope_queue.pop_front();
                    if (env_beat.envelope !== oldest.envelope)
                        report_mismatch("envelope", longint'(env_beat.envelope),
                                        longint'(oldest.envelope));
                    if (env_beat.first_of_line !== oldest.first_of_line)
                        report_mismatch("first_of_line", longint'(env_beat.first_of_line),
                                        longint'(oldest.first_of_line));
                    checks++;
                end
            end
        end
        error_count   <= mismatches;
        pending_count <= envelope_queue.size();
        checked_count <= checks;
    end

endmodule

// File: dv/hilbert_envelope_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hilbert_envelope_detector_tb
// Drives RF beats into the envelope detector: a directed set of extremes and
// line-start placements, then random scan lines of several signal shapes, with
// random gaps on the sender and random back-pressure on the receiver. The
// checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module hilbert_envelope_detector_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 550;
    localparam int PHASE_BEATS  = 110;
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        SHAPE_FULL,
        SHAPE_QUIET,
        SHAPE_RAIL,
        SHAPE_RAMP
    } line_shape_e;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               rf_valid  = 1'b0;
    logic               rf_ready;
    hed_pkg::rf_beat_t  rf_beat   = '0;
    logic               env_valid;
    logic               env_ready = 1'b0;
    hed_pkg::env_beat_t env_beat;

    int error_count;
    int pending_count;
    int checked_count;
    int cycle_count = 0;
    int beats_sent  = 0;
    int line_starts = 0;
    int stall_left  = 0;
    bit burst_mode  = 1'b0;

    hilbert_envelope_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rf_valid  (rf_valid),
        .rf_ready  (rf_ready),
        .rf_beat   (rf_beat),
        .env_valid (env_valid),
        .env_ready (env_ready),
        .env_beat  (env_beat)
    );

    hilbert_envelope_checker env_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .rf_valid      (rf_valid),
        .rf_ready      (rf_ready),
        .rf_beat       (rf_beat),
        .env_valid     (env_valid),
        .env_ready     (env_ready),
        .env_beat      (env_beat),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long; none in burst phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            env_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            env_ready  <= rst_n;
            stall_left <= pick_gap();
        end
    end

    // One RF beat, after a random gap; returns once accepted
    task automatic send_rf(input logic signed [hed_pkg::SAMPLE_BITS-1:0] sample,
                           input logic mark);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            rf_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rf_valid           <= 1'b1;
        rf_beat.rf_sample  <= sample;
        rf_beat.line_start <= mark;
        @(posedge clk);
        while (!rf_ready)
            @(posedge clk);
        beats_sent++;
        if (mark)
            line_starts++;
    endtask

    // Hold the sender off until every predicted envelope beat has come out
    task automatic wait_drained();
        @(negedge clk);
        rf_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                                     k;
        int                                     line_left;
        line_shape_e                            shape;
        logic signed [hed_pkg::SAMPLE_BITS-1:0] s;
        logic                                   mark;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: rails, blocks of equal extremes, zero step, line-start placements
        send_rf(16'sd0, 1'b1);
        repeat (4) send_rf(16'sd32767, 1'b0);
        repeat (4) send_rf(-16'sd32768, 1'b0);
        repeat (4) send_rf(16'sd32767, 1'b0);
        send_rf(16'sd0, 1'b1);
        repeat (2) send_rf(16'sd0, 1'b0);
        send_rf(16'sd1, 1'b1);
        send_rf(-16'sd1, 1'b1);
        send_rf(16'sd32767, 1'b1);
        send_rf(-16'sd32768, 1'b0);
        send_rf(16'sd21845, 1'b0);
        send_rf(-16'sd21846, 1'b0);
        send_rf(16'sd12345, 1'b0);
        send_rf(-16'sd12345, 1'b0);
        wait_drained();

        // Random scan lines; one phase without idling, one starting drained
        line_left = 0;
        shape     = SHAPE_FULL;
        s         = '0;
        for (k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k % PHASE_BEATS == 0)
            begin
                burst_mode = (k / PHASE_BEATS == 2);
                if (k / PHASE_BEATS == 3)
                    wait_drained();
            end
            mark = 1'b0;
            if (line_left == 0)
            begin
                mark      = 1'b1;
                line_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                        : $urandom_range(12, 70);
                shape     = line_shape_e'($urandom_range(0, 3));
            end
            line_left--;
            case (shape)
                SHAPE_FULL:  s = hed_pkg::SAMPLE_BITS'($urandom);
                SHAPE_QUIET: s = hed_pkg::SAMPLE_BITS'($urandom_range(0, 400) - 200);
                SHAPE_RAIL:  s = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                default:     s = s + hed_pkg::SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
            endcase
            // occasional stray sample inside any line
            if ($urandom_range(0, 31) == 0)
                s = hed_pkg::SAMPLE_BITS'($urandom);
            send_rf(s, mark);
        end

        burst_mode = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run: %0d RF beats over %0d scan lines, %0d envelope beats compared",
                 beats_sent, line_starts, checked_count);
        $display("Lines were full-scale, quiet, rail-to-rail and ramp, with and without stalls");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
